// ===== rtl/adrmd_pkg.sv =====
// Shared types and constants for the DC blocker, ring modulator and dither block.
// Used by the multiplier and the top level; no dependencies.
package adrmd_pkg;

    // Field and register widths.
    localparam int SAMP_W = 16;
    localparam int GAIN_W = 16;
    localparam int STEP_W = 27;
    localparam int POLE_W = 15;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Register reset values.
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;
    localparam logic [STEP_W-1:0] STEP_RST = 27'd2796203;
    localparam logic [POLE_W-1:0] POLE_RST = 15'd32745;
    localparam logic [31:0]       RNG_SEED = 32'h1234_5678;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_MUTE  = 2'd0,
        REG_GAIN  = 2'd1,
        REG_STEP  = 2'd2,
        REG_POLE  = 2'd3
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DC,
        S_GAIN,
        S_INTERP,
        S_SINE,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_CLAMP,
        S_ROUND,
        S_WRAP,
        S_OUT
    } t_state;

    // Operands for the shared multiplier.
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_op;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] v;
        v = x ^ (x << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

endpackage

// ===== rtl/audio_dc_block_ring_mod_dither.sv =====
// A transfer runs the sequencer from S_DC through S_OUT; S_WRAP subtracts one table period
// until the phase sum falls within it, and a muted transfer goes straight to S_OUT. A full output
// register holds the result back. A new sample is accepted only back in S_IDLE, so samples
// do not overlap; each uses the shared multiplier six times and the one-port table twice.
// Reset (synchronous, active low) restores register defaults, clears the blocker delay
// and phase, and reseeds the dither generator; the sine table is constant.
module audio_dc_block_ring_mod_dither
    import adrmd_pkg::*;
#(
    parameter int SINE_ENTRIES = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMP_W-1:0]    i_in_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMP_W-1:0]    o_out_sample,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = $clog2(SINE_ENTRIES);
    localparam int PH_W  = IDX_W + 16;
    localparam int SUM_W = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
    localparam logic [SUM_W-1:0] PERIOD = SUM_W'(SINE_ENTRIES) << 16;
    localparam logic signed [65:0] ONE47 = 66'sh8000_0000_0000;
    localparam logic [46:0] HALF47 = 47'h4000_0000_0000;

    // Configuration registers.
    logic              r_mute;
    logic [GAIN_W-1:0] r_gain;
    logic [STEP_W-1:0] r_step;
    logic [POLE_W-1:0] r_pole;

    // Persistent state.
    t_state              r_state, n_state;
    logic signed [31:0]  r_dc, n_dc;
    logic [PH_W-1:0]     r_phase, n_phase;
    logic [31:0]         r_rng, n_rng;
    logic                r_out_valid, n_out_valid;

    // Per-sample working registers.
    logic signed [24:0]  r_x24, n_x24;
    logic signed [32:0]  r_y, n_y;
    logic signed [15:0]  r_s0, n_s0;
    logic signed [15:0]  r_s1, n_s1;
    logic signed [41:0]  r_v, n_v;
    logic signed [25:0]  r_s, n_s;
    logic [23:0]         r_u1, n_u1;
    logic signed [24:0]  r_dith, n_dith;
    logic signed [65:0]  r_acc, n_acc;
    logic signed [48:0]  r_t, n_t;
    logic [SUM_W-1:0]    r_psum, n_psum;
    logic [SAMP_W-1:0]   r_res, n_res;
    logic [SAMP_W-1:0]   r_out, n_out;

    // Shared units.
    t_mul_op                    w_mul_op;
    logic signed [MUL_P_W-1:0]  w_prod;
    logic [IDX_W-1:0]           w_rom_addr;
    logic signed [15:0]         w_rom_data;
    logic [IDX_W-1:0]           w_idx;
    logic [IDX_W-1:0]           w_idx1;
    logic                       w_in_xfer;
    logic                       w_cfg_wr;

    adrmd_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (w_mul_op),
        .o_prod (w_prod)
    );

    adrmd_sine_rom #(.SINE_ENTRIES(SINE_ENTRIES)) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Handshake and configuration port.
    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = $signed(r_out);
    assign pready       = 1'b1;
    assign w_cfg_wr     = psel && penable && pwrite && pready;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_MUTE: prdata = {31'd0, r_mute};
            REG_GAIN: prdata = {16'd0, r_gain};
            REG_STEP: prdata = {5'd0, r_step};
            REG_POLE: prdata = {17'd0, r_pole};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute <= 1'b0;
            r_gain <= GAIN_RST;
            r_step <= STEP_RST;
            r_pole <= POLE_RST;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_MUTE: r_mute <= pwdata[0];
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                REG_STEP: r_step <= pwdata[STEP_W-1:0];
                REG_POLE: r_pole <= pwdata[POLE_W-1:0];
                default:  r_mute <= r_mute;
            endcase
        end
    end

    // Table addresses of the two interpolation points.
    assign w_idx  = r_phase[PH_W-1:16];
    assign w_idx1 = (w_idx == IDX_W'(SINE_ENTRIES - 1)) ? '0 : w_idx + 1'b1;

    // Sequencer: next state, datapath updates and multiplier operands.
    always_comb begin
        logic [31:0]        rng_nx;
        logic signed [36:0] dc_scaled;
        logic signed [37:0] dc_diff;
        logic signed [43:0] v_full;
        logic signed [16:0] s_diff;
        logic signed [34:0] sq;
        logic signed [65:0] t_sum;
        logic signed [63:0] w_scaled;
        logic [46:0]        rem;
        logic               inc;

        n_state     = r_state;
        n_dc        = r_dc;
        n_phase     = r_phase;
        n_rng       = r_rng;
        n_out_valid = r_out_valid;
        n_x24       = r_x24;
        n_y         = r_y;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_v         = r_v;
        n_s         = r_s;
        n_u1        = r_u1;
        n_dith      = r_dith;
        n_acc       = r_acc;
        n_t         = r_t;
        n_psum      = r_psum;
        n_res       = r_res;
        n_out       = r_out;
        w_mul_op.a  = 34'(r_y);
        w_mul_op.b  = 18'($signed({3'b000, r_pole}));
        w_rom_addr  = w_idx;

        rng_nx    = xorshift32(r_rng);
        dc_scaled = 37'((w_prod + 52'sd16384) >>> 15);
        dc_diff   = 38'(dc_scaled) - 38'(r_x24);
        v_full    = 44'((w_prod + 52'sd128) >>> 8);
        s_diff    = 17'(r_s1) - 17'(r_s0);
        sq        = (35'(r_s0) <<< 16) + 35'(w_prod);
        t_sum     = r_acc + (66'(r_dith) <<< 8);
        w_scaled  = (64'(r_t) <<< 15) - 64'(r_t);
        rem       = w_scaled[46:0];
        inc       = (rem > HALF47) || ((rem == HALF47) && w_scaled[47]);

        // The output register drains whenever the far side takes a transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (r_mute) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_x24   = 25'(i_in_sample) <<< 9;
                        n_y     = 33'(25'(i_in_sample) <<< 9) + 33'(r_dc);
                        n_state = S_DC;
                    end
                end
            end
            S_DC: begin
                // Blocker feedback product; second table read.
                n_s0       = w_rom_data;
                w_rom_addr = w_idx1;
                n_state    = S_GAIN;
            end
            S_GAIN: begin
                // New blocker delay, saturated to 32 bits; gain product.
                if (dc_diff > 38'sd2147483647)
                    n_dc = 32'sh7FFF_FFFF;
                else if (dc_diff < -38'sd2147483648)
                    n_dc = 32'sh8000_0000;
                else
                    n_dc = dc_diff[31:0];
                n_s1       = w_rom_data;
                w_mul_op.b = 18'($signed({2'b00, r_gain}));
                n_state    = S_INTERP;
            end
            S_INTERP: begin
                // Scaled sample; interpolation product.
                n_v        = 42'(v_full);
                w_mul_op.a = 34'(s_diff);
                w_mul_op.b = 18'($signed({2'b00, r_phase[15:0]}));
                n_state    = S_SINE;
            end
            S_SINE: begin
                // Interpolated sine and the first dither draw.
                n_s     = 26'((sq + 35'sd128) >>> 8);
                n_rng   = rng_nx;
                n_u1    = rng_nx[23:0];
                n_state = S_P0;
            end
            S_P0: begin
                // Low slice of the modulation product; second dither draw.
                w_mul_op.a = 34'(r_s);
                w_mul_op.b = 18'($signed({1'b0, r_v[16:0]}));
                n_rng      = rng_nx;
                n_dith     = $signed({1'b0, r_u1}) - $signed({1'b0, rng_nx[23:0]});
                n_state    = S_P1;
            end
            S_P1: begin
                w_mul_op.a = 34'(r_s);
                w_mul_op.b = 18'($signed({1'b0, r_v[33:17]}));
                n_acc      = 66'(w_prod);
                n_state    = S_P2;
            end
            S_P2: begin
                w_mul_op.a = 34'(r_s);
                w_mul_op.b = 18'($signed(r_v[41:34]));
                n_acc      = r_acc + (66'(w_prod) <<< 17);
                n_state    = S_P3;
            end
            S_P3: begin
                n_acc   = r_acc + (66'(w_prod) <<< 34);
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                // Add dither and clamp to [-1, 1]; start the phase advance.
                if (t_sum > ONE47)
                    n_t = 49'(ONE47);
                else if (t_sum < -ONE47)
                    n_t = 49'(-ONE47);
                else
                    n_t = 49'(t_sum);
                n_psum  = SUM_W'(r_phase) + SUM_W'(r_step);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // Scale by 32767 and round half to even.
                n_res   = w_scaled[62:47] + SAMP_W'(inc);
                n_state = S_WRAP;
            end
            S_WRAP: begin
                // Bring the phase back into one table period.
                if (r_psum >= PERIOD) begin
                    n_psum = r_psum - PERIOD;
                end else begin
                    n_phase = r_psum[PH_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dc        <= '0;
            r_phase     <= '0;
            r_rng       <= RNG_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dc        <= n_dc;
            r_phase     <= n_phase;
            r_rng       <= n_rng;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_x24  <= n_x24;
        r_y    <= n_y;
        r_s0   <= n_s0;
        r_s1   <= n_s1;
        r_v    <= n_v;
        r_s    <= n_s;
        r_u1   <= n_u1;
        r_dith <= n_dith;
        r_acc  <= n_acc;
        r_t    <= n_t;
        r_psum <= n_psum;
        r_res  <= n_res;
        r_out  <= n_out;
    end

`ifndef SYNTH
    // A muted transfer yields a zero result.
    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_mute) |=> (r_res == '0))
        else $error("muted sample did not produce zero");

    // An unmuted transfer starts the multiply sequence.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !r_mute) |=> (r_state == S_DC))
        else $error("sequencer did not start after a transfer");

    // The phase stays within one table period.
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_phase) < PERIOD))
        else $error("phase outside table period");

    // The dither generator never falls into the all-zero state.
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rng != '0))
        else $error("dither generator stuck at zero");
`endif

endmodule

// ===== rtl/adrmd_sine_rom.sv =====
// One-period sine table with a registered read port.
// Contents are computed at elaboration; no package dependencies.
module adrmd_sine_rom #(
    parameter int SINE_ENTRIES = 2048,
    localparam int IDX_W = $clog2(SINE_ENTRIES)
) (
    input  logic                    i_clk,
    input  logic [IDX_W-1:0]        i_addr,
    output logic signed [15:0]      o_data
);

    typedef logic signed [15:0] t_rom_arr [SINE_ENTRIES];

    // pi/4 in Q.32.
    localparam logic [63:0] PI4_Q32 = 64'd3373259426;

    // Series term divisors for the sine expansion.
    function automatic logic [63:0] sin_div(input logic [63:0] x, input int k);
        logic [63:0] r;
        case (k)
            1:       r = x / 6;
            2:       r = x / 20;
            3:       r = x / 42;
            4:       r = x / 72;
            5:       r = x / 110;
            6:       r = x / 156;
            7:       r = x / 210;
            8:       r = x / 272;
            default: r = x / 342;
        endcase
        return r;
    endfunction

    // Series term divisors for the cosine expansion.
    function automatic logic [63:0] cos_div(input logic [63:0] x, input int k);
        logic [63:0] r;
        case (k)
            1:       r = x / 2;
            2:       r = x / 12;
            3:       r = x / 30;
            4:       r = x / 56;
            5:       r = x / 90;
            6:       r = x / 132;
            7:       r = x / 182;
            8:       r = x / 240;
            default: r = x / 306;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] sin_q32(input logic [63:0] phi);
        logic [63:0]        p2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        p2   = (phi * phi) >> 32;
        term = phi;
        sum  = $signed(phi);
        for (int k = 1; k <= 9; k++) begin
            term = sin_div((term * p2) >> 32, k);
            sum  = (k % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] cos_q32(input logic [63:0] phi);
        logic [63:0]        p2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        p2   = (phi * phi) >> 32;
        term = 64'd1 << 32;
        sum  = $signed(term);
        for (int k = 1; k <= 9; k++) begin
            term = cos_div((term * p2) >> 32, k);
            sum  = (k % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
        end
        return sum;
    endfunction

    // One table entry: octant folding, series evaluation and rounding.
    function automatic logic signed [15:0] rom_entry(input int i);
        int                 q;
        int                 oct;
        int                 r;
        int                 num;
        logic [63:0]        phi;
        logic [63:0]        mag;
        logic signed [63:0] s;
        if ((12 * i) % SINE_ENTRIES == 0) begin
            q = (12 * i) / SINE_ENTRIES;
            if (q == 1 || q == 5) return 16'sd16384;
            if (q == 7 || q == 11) return -16'sd16384;
        end
        oct = (8 * i) / SINE_ENTRIES;
        r   = (8 * i) % SINE_ENTRIES;
        num = (oct % 2 == 1) ? SINE_ENTRIES - r : r;
        phi = (64'(num) * PI4_Q32 + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
        if (oct == 1 || oct == 2 || oct == 5 || oct == 6)
            s = cos_q32(phi);
        else
            s = sin_q32(phi);
        if (s < 0) s = 0;
        mag = (64'(s) * 64'd32767 + (64'd1 << 31)) >> 32;
        if (mag > 64'd32767) mag = 64'd32767;
        return (oct >= 4) ? -$signed(16'(mag)) : $signed(16'(mag));
    endfunction

    function automatic t_rom_arr rom_build();
        t_rom_arr t;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            t[i] = rom_entry(i);
        end
        return t;
    endfunction

    localparam t_rom_arr ROM_DATA = rom_build();

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_data <= ROM_DATA[i_addr];
    end

endmodule

// ===== rtl/adrmd_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on adrmd_pkg for the operand struct and widths.
module adrmd_mul
    import adrmd_pkg::*;
(
    input  logic                        i_clk,
    input  t_mul_op                     i_op,
    output logic signed [MUL_P_W-1:0]   o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_op.a) * MUL_P_W'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

// ===== sim/adrmd_checker.sv =====
// Checker for the DC blocker, ring modulator and dither block: watches both sample
// channels and the register port, predicts every output sample and compares.
// Depends on adrmd_pkg for widths and register indexes.
module adrmd_checker
    import adrmd_pkg::*;
#(
    parameter int SINE_ENTRIES = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic signed [SAMP_W-1:0] i_in_sample,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [SAMP_W-1:0] i_out_sample,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [3:0]               i_paddr,
    input  logic [31:0]              i_pwdata,
    input  logic                     i_pready,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam longint ONE47 = 64'sd1 << 47;
    localparam longint unsigned PI4_Q32 = 64'd3373259426;

    // Predicted copy of the block's registers and state.
    logic                   mute_q;
    logic [GAIN_W-1:0]      gain_q;
    logic [STEP_W-1:0]      step_q;
    logic [POLE_W-1:0]      pole_q;
    logic signed [31:0]     dc_delay_q;
    logic [31:0]            phase_q;
    logic [31:0]            rng_q;
    logic signed [15:0]     sine_tab [SINE_ENTRIES];
    logic signed [SAMP_W-1:0] expected_samples [$];

    // Taylor series for sine or cosine of an angle up to pi/4, all in Q.32.
    function automatic longint taylor_q32(input longint unsigned phi, input bit want_cos);
        longint unsigned p2, term;
        longint          sum;
        longint unsigned div;
        p2 = (phi * phi) >> 32;
        term = want_cos ? (64'd1 << 32) : phi;
        sum = longint'(term);
        for (int k = 1; k <= 9; k++) begin
            div = want_cos ? longint'((2 * k - 1) * (2 * k)) : longint'((2 * k) * (2 * k + 1));
            term = ((term * p2) >> 32) / div;
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        return sum;
    endfunction

    // One table entry, built by octant symmetry around the series.
    function automatic logic signed [15:0] sine_word(input int unsigned i);
        int unsigned n, oct, r, num, q;
        longint unsigned phi, mag;
        longint s;
        n = SINE_ENTRIES;
        if ((12 * i) % n == 0) begin
            q = (12 * i) / n;
            if (q == 1 || q == 5) return 16'sd16384;
            if (q == 7 || q == 11) return -16'sd16384;
        end
        oct = (8 * i) / n;
        r = (8 * i) % n;
        num = oct[0] ? n - r : r;
        phi = (longint'(num) * PI4_Q32 + n / 2) / n;
        s = taylor_q32(phi, oct == 1 || oct == 2 || oct == 5 || oct == 6);
        if (s < 0) s = 0;
        mag = (longint'(s) * 64'd32767 + (64'd1 << 31)) >> 32;
        if (mag > 32767) mag = 32767;
        return (oct >= 4) ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    endfunction

    // Advance the dither generator and return the low 24 bits of the draw.
    function automatic longint next_dither();
        logic [31:0] x;
        x = rng_q;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng_q = x;
        return longint'({8'd0, x[23:0]});
    endfunction

    // Full datapath for one accepted sample; updates the predicted state.
    function automatic logic signed [SAMP_W-1:0] process_sample(
        input logic signed [SAMP_W-1:0] smp);
        longint x24, y, d, v, sq, s, p, t, w, q, rem, u1, u2, a0, a1, fr;
        int unsigned idx, idx1;
        if (mute_q) return '0;
        x24 = longint'(smp) * 512;
        y = x24 + longint'(dc_delay_q);
        d = ((y * longint'({1'b0, pole_q}) + 16384) >>> 15) - x24;
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        dc_delay_q = d[31:0];
        v = (y * longint'({1'b0, gain_q}) + 128) >>> 8;
        idx = (phase_q >> 16) % SINE_ENTRIES;
        idx1 = (idx + 1) % SINE_ENTRIES;
        fr = longint'({16'd0, phase_q[15:0]});
        a0 = longint'(sine_tab[idx]);
        a1 = longint'(sine_tab[idx1]);
        sq = a0 * 65536 + fr * (a1 - a0);
        s = (sq + 128) >>> 8;
        p = v * s;
        u1 = next_dither();
        u2 = next_dither();
        t = p + (u1 - u2) * 256;
        if (t > ONE47) t = ONE47;
        if (t < -ONE47) t = -ONE47;
        w = t * 32767;
        q = w >>> 47;
        rem = w - q * ONE47;
        if (rem > ONE47 / 2 || (rem == ONE47 / 2 && q[0])) q = q + 1;
        phase_q = (phase_q + {5'd0, step_q}) % (SINE_ENTRIES * 65536);
        return q[15:0];
    endfunction

    initial begin
        for (int i = 0; i < SINE_ENTRIES; i++) sine_tab[i] = sine_word(i);
    end

    assign o_pending = expected_samples.size();

    // Track register writes, predict on input transfers, check output transfers.
    always @(posedge i_clk) begin
        logic signed [SAMP_W-1:0] want;
        if (!i_rst_n) begin
            mute_q <= 1'b0;
            gain_q <= GAIN_RST;
            step_q <= STEP_RST;
            pole_q <= POLE_RST;
            dc_delay_q = '0;
            phase_q = '0;
            rng_q = RNG_SEED;
            o_fail_count <= 0;
            expected_samples.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("out_sample: unexpected transfer, value %0d", i_out_sample);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (want !== i_out_sample) begin
                        $error("out_sample: expected %0d, got %0d", want, i_out_sample);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_samples.push_back(process_sample(i_in_sample));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_MUTE: mute_q <= i_pwdata[0];
                    REG_GAIN: gain_q <= i_pwdata[GAIN_W-1:0];
                    REG_STEP: step_q <= i_pwdata[STEP_W-1:0];
                    REG_POLE: pole_q <= i_pwdata[POLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/audio_dc_block_ring_mod_dither_test.sv =====
// Testbench top for audio_dc_block_ring_mod_dither: drives samples and register
// writes through several settings and reports the verdict. Uses adrmd_checker.
module audio_dc_block_ring_mod_dither_test;
    import adrmd_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [SAMP_W-1:0] i_in_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [SAMP_W-1:0] o_out_sample;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [3:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    audio_dc_block_ring_mod_dither u_top (.*);

    adrmd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_sample(i_in_sample),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_sample(o_out_sample),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: long stretches of steady readiness alternate with random stalls.
    always @(posedge i_clk) begin
        int mode_left;
        int stall_pct;
        if (mode_left == 0) begin
            mode_left = $urandom_range(10, 200);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        end
        mode_left = mode_left - 1;
        i_out_ready <= ($urandom_range(1, 100) > stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sample transfer; valid stays high into the next sample unless a gap follows.
    task automatic send_sample(input logic signed [SAMP_W-1:0] smp, input int gap);
        i_in_valid <= 1'b1;
        i_in_sample <= smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for all results plus the block's own tail before touching registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // Random sample: mostly full range, some small, some at the rails.
    function automatic logic signed [SAMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1, 2: return $signed(16'($urandom_range(0, 511)) - 16'd256);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // Send a run of samples in bursts with random gaps.
    task automatic send_run(input int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) burst = $urandom_range(1, 20);
            burst = burst - 1;
            send_sample(pick_sample(), (burst == 0) ? $urandom_range(1, 20) : 0);
        end
    endtask

    initial begin
        logic signed [SAMP_W-1:0] directed [12];
        directed = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF,
                     16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0000};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes at the reset settings, including a constant run at each rail.
        foreach (directed[k]) send_sample(directed[k], k % 3);
        drain();

        // Maximum gain, maximum pole and a phase step that wraps the table.
        write_reg(REG_GAIN, 32'hFFFF);
        write_reg(REG_POLE, 32'h7FFF);
        write_reg(REG_STEP, 32'h7FF_FFFF);
        for (int k = 0; k < 6; k++) send_sample(k[0] ? 16'sh7FFF : 16'sh8000, 0);
        drain();

        // Minimum settings: zero gain, zero pole, frozen phase.
        write_reg(REG_GAIN, 32'h0);
        write_reg(REG_POLE, 32'h0);
        write_reg(REG_STEP, 32'h0);
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        drain();

        // Muted: output zero and state frozen, then resume.
        write_reg(REG_GAIN, 32'd256);
        write_reg(REG_MUTE, 32'h1);
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh1234, 1);
        drain();
        write_reg(REG_MUTE, 32'h0);
        send_sample(16'sh7FFF, 0);
        drain();

        // Random phases under a mix of settings.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: write_reg(REG_GAIN, $urandom_range(0, 1024));
                1: write_reg(REG_GAIN, $urandom_range(0, 65535));
                2: write_reg(REG_STEP, $urandom_range(0, 32'h7FF_FFFF));
                3: write_reg(REG_POLE, $urandom_range(30000, 32767));
                default: write_reg(REG_POLE, $urandom_range(0, 32767));
            endcase
            write_reg(REG_STEP, $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h7FF_FFFF)
                                                          : $urandom_range(0, 8000000));
            write_reg(REG_MUTE, ($urandom_range(0, 7) == 0) ? 32'h1 : 32'h0);
            send_run(48);
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
